[rtl/mkt_pkg.sv]
// shared types, widths and constants of the morse key timing tokenizer
package mkt_pkg;

  localparam int TIME_W        = 32;
  localparam int UNIT_W        = 17;
  localparam int THR_W         = 21;
  localparam int CNT_W         = 7;
  localparam int BUF_DEPTH_DEF = 64;
  localparam int UNIT_RESET    = 100;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [2:0] {
    TOK_DOT   = 3'd0,
    TOK_DASH  = 3'd1,
    TOK_ECHAR = 3'd2,
    TOK_SPACE = 3'd3,
    TOK_EMSG  = 3'd4
  } tok_t;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_READOUT = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_STATUS,
    CMD_READ,
    CMD_EMPTY
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    tok_t             tok;
    logic             ready;
    logic [CNT_W-1:0] num;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIFF,
    F_CMP,
    F_KEY,
    F_GAP,
    F_END,
    F_STAT,
    F_TAKE
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_READ
  } back_state_t;

endpackage

[rtl/morse_key_timing_tokenizer.sv]
// top level of the morse key timing tokenizer
// A tick beat (op 0) passes the front steps diff, compare, key, gap, end and status
// and gives one status beat; a take beat (op 1) passes the take step, after which
// the back part streams one readout beat per cycle from the token ram, n beats for
// n tokens, or gives a single empty-take beat. Each front step that may hand a
// command to the back stalls while the command queue is full.
// busy is high while the front works on a beat; the command queue lets the front
// accept the next beat while the back still streams tokens. Results appear on the
// result ports for one cycle each, marked by strobe, and cannot be held off, so
// they must be taken as they come.
module morse_key_timing_tokenizer import mkt_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              pressed,
  input  logic              released,
  input  logic [CNT_W-1:0]  max_tokens,
  input  logic              cfg_we,
  input  logic [UNIT_W-1:0] cfg_data,
  output logic              strobe,
  output logic [1:0]        kind,
  output logic [2:0]        token,
  output logic              ready_res,
  output logic [CNT_W-1:0]  count,
  output logic              last
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  mkt_front #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .now_ms    (now_ms),
    .pressed   (pressed),
    .released  (released),
    .max_tokens(max_tokens),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (front_cmd),
    .q_full    (q_full)
  );

  mkt_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (back_cmd),
    .empty    (q_empty)
  );

  mkt_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (back_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .strobe   (strobe),
    .kind     (kind),
    .token    (token),
    .ready_res(ready_res),
    .count    (count),
    .last     (last)
  );

endmodule

[rtl/mkt_ram.sv]
// generic single write port ram with registered read
module mkt_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mkt_fifo.sv]
// short command queue between the front and back parts
module mkt_fifo import mkt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] fill;

  assign full     = (fill == CW'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command queue overflow");

endmodule

[rtl/mkt_front.sv]
// front part: takes items, times key events and decides which tokens to push
module mkt_front import mkt_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              pressed,
  input  logic              released,
  input  logic [CNT_W-1:0]  max_tokens,
  input  logic              cfg_we,
  input  logic [UNIT_W-1:0] cfg_data,
  output logic              q_push,
  output cmd_t              q_data,
  input  logic              q_full
);

  front_state_t      state;
  front_state_t      state_next;
  logic              it_op;
  logic [TIME_W-1:0] it_now;
  logic              it_pr;
  logic              it_rl;
  logic [CNT_W-1:0]  it_maxt;
  logic              key_down;
  logic [TIME_W-1:0] press_time;
  logic [TIME_W-1:0] release_time;
  logic [CNT_W-1:0]  fill;
  tok_t              last_tok;
  logic              msg_done;
  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] gap;
  logic              sh;
  logic              g3;
  logic              g7;
  logic              g10;
  logic [THR_W-1:0]  thr2;
  logic [THR_W-1:0]  thr3;
  logic [THR_W-1:0]  thr7;
  logic [THR_W-1:0]  thr10;
  logic              accept;
  logic              gap_on;
  logic              room;
  logic              do_push;
  tok_t              push_tok;
  logic              set_done;
  logic              take_clear;
  logic [CNT_W-1:0]  take_n;

  assign busy   = (state != F_IDLE);
  assign accept = (state == F_IDLE) && start;
  assign gap_on = !key_down && (fill != '0) && !msg_done;
  assign room   = (fill < CNT_W'(BUF_DEPTH));
  assign take_n = (fill < it_maxt) ? fill : it_maxt;

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    q_data     = '{op: CMD_PUSH, tok: TOK_DOT, ready: 1'b0, num: fill};
    do_push    = 1'b0;
    push_tok   = TOK_DOT;
    set_done   = 1'b0;
    take_clear = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (start) begin
          state_next = op ? F_TAKE : F_DIFF;
        end
      end
      F_DIFF: state_next = F_CMP;
      F_CMP:  state_next = F_KEY;
      F_KEY: begin
        if (!q_full) begin
          if (it_rl) begin
            do_push  = 1'b1;
            push_tok = sh ? TOK_DOT : TOK_DASH;
          end
          state_next = F_GAP;
        end
      end
      F_GAP: begin
        if (!q_full) begin
          if (gap_on) begin
            if (g7) begin
              if (last_tok != TOK_SPACE && last_tok != TOK_EMSG) begin
                do_push  = 1'b1;
                push_tok = TOK_SPACE;
              end
            end else if (g3) begin
              if (last_tok != TOK_ECHAR && last_tok != TOK_SPACE &&
                  last_tok != TOK_EMSG) begin
                do_push  = 1'b1;
                push_tok = TOK_ECHAR;
              end
            end
          end
          state_next = F_END;
        end
      end
      F_END: begin
        if (!q_full) begin
          if (gap_on && g10) begin
            if (last_tok != TOK_EMSG) begin
              do_push  = 1'b1;
              push_tok = TOK_EMSG;
            end
            set_done = 1'b1;
          end
          state_next = F_STAT;
        end
      end
      F_STAT: begin
        if (!q_full) begin
          q_push     = 1'b1;
          q_data     = '{op: CMD_STATUS, tok: TOK_DOT, ready: msg_done, num: fill};
          state_next = F_IDLE;
        end
      end
      F_TAKE: begin
        if (!q_full) begin
          q_push = 1'b1;
          if (!msg_done) begin
            q_data = '{op: CMD_EMPTY, tok: TOK_DOT, ready: 1'b0, num: '0};
          end else begin
            take_clear = 1'b1;
            if (take_n == '0) begin
              q_data = '{op: CMD_EMPTY, tok: TOK_DOT, ready: 1'b0, num: '0};
            end else begin
              q_data = '{op: CMD_READ, tok: TOK_DOT, ready: 1'b0, num: take_n};
            end
          end
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
    if (do_push && room) begin
      q_push = 1'b1;
      q_data = '{op: CMD_PUSH, tok: push_tok, ready: 1'b0, num: fill};
    end
  end

  // item latch and timing datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      it_op   <= op;
      it_now  <= now_ms;
      it_pr   <= pressed;
      it_rl   <= released;
      it_maxt <= max_tokens;
    end
    if (state == F_DIFF) begin
      dur <= it_now - (it_pr ? it_now : press_time);
      gap <= it_rl ? '0 : it_now - release_time;
    end
    if (state == F_CMP) begin
      sh  <= (dur < TIME_W'(thr2));
      g3  <= (gap >= TIME_W'(thr3));
      g7  <= (gap >= TIME_W'(thr7));
      g10 <= (gap >= TIME_W'(thr10));
    end
    if (q_push && q_data.op == CMD_PUSH) begin
      last_tok <= q_data.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      key_down     <= 1'b0;
      press_time   <= '0;
      release_time <= '0;
      fill         <= '0;
      msg_done     <= 1'b0;
      thr2         <= THR_W'(2 * UNIT_RESET);
      thr3         <= THR_W'(3 * UNIT_RESET);
      thr7         <= THR_W'(7 * UNIT_RESET);
      thr10        <= THR_W'(10 * UNIT_RESET);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        thr2  <= THR_W'({cfg_data, 1'b0});
        thr3  <= THR_W'({cfg_data, 1'b0}) + THR_W'(cfg_data);
        thr7  <= THR_W'({cfg_data, 3'b000}) - THR_W'(cfg_data);
        thr10 <= THR_W'({cfg_data, 3'b000}) + THR_W'({cfg_data, 1'b0});
      end
      if (state == F_DIFF) begin
        if (it_pr) begin
          press_time <= it_now;
        end
        key_down <= it_rl ? 1'b0 : (it_pr ? 1'b1 : key_down);
        if (it_rl) begin
          release_time <= it_now;
        end
      end
      if (q_push && q_data.op == CMD_PUSH) begin
        fill <= fill + CNT_W'(1);
      end
      if (set_done) begin
        msg_done <= 1'b1;
      end
      if (take_clear) begin
        fill         <= '0;
        msg_done     <= 1'b0;
        release_time <= it_now;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(BUF_DEPTH))
    else $error("fill level beyond buffer depth");

  a_done_has_tokens: assert property (@(posedge clk) disable iff (rst)
    msg_done |-> (fill != '0))
    else $error("message marked ready with empty buffer");

  a_take_from_op: assert property (@(posedge clk) disable iff (rst)
    (state == F_TAKE) |-> it_op)
    else $error("take step entered for a tick beat");

endmodule

[rtl/mkt_back.sv]
// back part: writes tokens, reads them out and drives the result ports
module mkt_back import mkt_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             strobe,
  output logic [1:0]       kind,
  output logic [2:0]       token,
  output logic             ready_res,
  output logic [CNT_W-1:0] count,
  output logic             last
);

  localparam int AW = $clog2(BUF_DEPTH);

  back_state_t      state;
  back_state_t      state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] n_reg;
  logic             rd_v;
  logic             rd_last;
  logic             o_valid;
  kind_t            o_kind;
  logic             o_ready;
  logic [CNT_W-1:0] o_count;
  logic             ram_we;
  logic             ram_re;
  logic [2:0]       ram_rdata;

  assign q_pop   = (state == B_IDLE) && !q_empty;
  assign idx_inc = idx + CNT_W'(1);
  assign ram_we  = q_pop && (q_data.op == CMD_PUSH);
  assign ram_re  = (state == B_READ);

  mkt_ram #(
    .WIDTH(3),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(q_data.num[AW-1:0]),
    .wdata(q_data.tok),
    .re   (ram_re),
    .raddr(idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_pop && q_data.op == CMD_READ) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        if (idx_inc == n_reg) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      o_kind  <= (q_data.op == CMD_STATUS) ? KIND_STATUS : KIND_EMPTY;
      o_ready <= (q_data.op == CMD_STATUS) ? q_data.ready : 1'b0;
      o_count <= (q_data.op == CMD_STATUS) ? q_data.num : '0;
      if (q_data.op == CMD_READ) begin
        n_reg <= q_data.num;
        idx   <= '0;
      end
    end
    if (state == B_READ) begin
      idx <= idx_inc;
    end
    rd_last <= (idx_inc == n_reg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      rd_v    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_v    <= (state == B_READ);
      o_valid <= q_pop && (q_data.op == CMD_STATUS || q_data.op == CMD_EMPTY);
    end
  end

  assign strobe    = rd_v || o_valid;
  assign kind      = rd_v ? KIND_READOUT : o_kind;
  assign token     = rd_v ? ram_rdata : TOK_DOT;
  assign ready_res = rd_v ? 1'b0 : o_ready;
  assign count     = rd_v ? n_reg : o_count;
  assign last      = rd_v ? rd_last : 1'b1;

  a_one_source: assert property (@(posedge clk) disable iff (rst) !(rd_v && o_valid))
    else $error("readout and status beat collide");

  a_read_nonzero: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.op == CMD_READ) |-> (q_data.num != '0))
    else $error("readout command with no tokens");

endmodule
